// ----- design/rhsv_pkg.sv -----
// rhsv_pkg: shared types for the RGB to HSV pixel converter.
// No dependencies; used by rhsv_front.
package rhsv_pkg;

    // Hue sector, chosen by which channel holds the maximum.
    // Ties go to red first, then green.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

// ----- design/rhsv_front.sv -----
// rhsv_front: two register stages that form max, min, chroma, the hue numerator
// and both division operands. Depends on rhsv_pkg.
module rhsv_front #(
    parameter int CHANNEL_BITS = 8,
    parameter int HDW          = CHANNEL_BITS + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // upstream side
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    // downstream side
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [HDW-1:0]          o_hue_rem,
    output logic [HDW-1:0]          o_hue_div,
    output logic [CHANNEL_BITS-1:0] o_sat_rem,
    output logic [CHANNEL_BITS-1:0] o_sat_low,
    output logic [CHANNEL_BITS-1:0] o_sat_div,
    output logic [CHANNEL_BITS-1:0] o_brightness
);

    localparam int CB  = CHANNEL_BITS;
    localparam int NW  = CB + 4;

    logic                 r1_valid;
    logic                 r2_valid;
    logic                 w_rdy1;
    logic                 w_rdy2;

    // stage 1 registers
    logic [CB-1:0]        r1_max;
    logic [CB-1:0]        r1_min;
    rhsv_pkg::t_sector    r1_sec;
    logic signed [CB:0]   r1_diff;

    logic [CB-1:0]        n1_max;
    logic [CB-1:0]        n1_min;
    rhsv_pkg::t_sector    n1_sec;
    logic signed [CB:0]   n1_diff;

    // stage 2 registers
    logic [HDW-1:0]       r2_hue_rem;
    logic [HDW-1:0]       r2_hue_div;
    logic [CB-1:0]        r2_sat_rem;
    logic [CB-1:0]        r2_sat_low;
    logic [CB-1:0]        r2_sat_div;
    logic [CB-1:0]        r2_bright;

    logic [HDW-1:0]       n2_hue_rem;
    logic [HDW-1:0]       n2_hue_div;
    logic [CB-1:0]        n2_sat_div;
    logic [2*CB-1:0]      n2_sat_dvd;

    logic [CB-1:0]        w_chroma;
    logic signed [NW-1:0] w_c_s;
    logic signed [NW-1:0] w_off;
    logic signed [NW-1:0] w_diff;
    logic signed [NW-1:0] w_num;
    logic [HDW-1:0]       w_six_c;

    // stall chain: a stage can load when it is empty or its successor moves
    assign w_rdy2  = !r2_valid || i_ready;
    assign w_rdy1  = !r1_valid || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r2_valid;

    // stage 1: pick the sector, max, min and the signed channel difference
    always_comb begin
        n1_min = i_red;
        if (i_green < n1_min) begin
            n1_min = i_green;
        end
        if (i_blue < n1_min) begin
            n1_min = i_blue;
        end
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n1_sec  = rhsv_pkg::SEC_RED;
            n1_max  = i_red;
            n1_diff = signed'({1'b0, i_green}) - signed'({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n1_sec  = rhsv_pkg::SEC_GREEN;
            n1_max  = i_green;
            n1_diff = signed'({1'b0, i_blue}) - signed'({1'b0, i_red});
        end else begin
            n1_sec  = rhsv_pkg::SEC_BLUE;
            n1_max  = i_blue;
            n1_diff = signed'({1'b0, i_red}) - signed'({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_max  <= n1_max;
            r1_min  <= n1_min;
            r1_sec  <= n1_sec;
            r1_diff <= n1_diff;
        end
    end

    // stage 2: chroma, hue numerator wrapped into [0, 6c), division operands
    always_comb begin
        w_chroma = r1_max - r1_min;
        w_c_s    = signed'({4'b0, w_chroma});
        w_diff   = signed'({{3{r1_diff[CB]}}, r1_diff});
        unique case (r1_sec)
            rhsv_pkg::SEC_RED:   w_off = '0;
            rhsv_pkg::SEC_GREEN: w_off = w_c_s <<< 1;
            rhsv_pkg::SEC_BLUE:  w_off = w_c_s <<< 2;
            default:             w_off = '0;
        endcase
        w_num = w_off + w_diff;
        if (w_num[NW-1]) begin
            w_num = w_num + (w_c_s <<< 2) + (w_c_s <<< 1);
        end
        w_six_c    = {1'b0, w_chroma, 2'b00} + {2'b00, w_chroma, 1'b0};
        n2_hue_rem = w_num[HDW-1:0];
        // a grey pixel divides zero by all ones, which gives a zero quotient
        n2_hue_div = (w_chroma == '0) ? '1 : w_six_c;
        // chroma * (2^CB - 1) as a shift and a subtract
        n2_sat_dvd = {w_chroma, {CB{1'b0}}} - {{CB{1'b0}}, w_chroma};
        n2_sat_div = (r1_max == '0) ? '1 : r1_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_valid) begin
            r2_hue_rem <= n2_hue_rem;
            r2_hue_div <= n2_hue_div;
            r2_sat_rem <= n2_sat_dvd[2*CB-1:CB];
            r2_sat_low <= n2_sat_dvd[CB-1:0];
            r2_sat_div <= n2_sat_div;
            r2_bright  <= r1_max;
        end
    end

    assign o_hue_rem    = r2_hue_rem;
    assign o_hue_div    = r2_hue_div;
    assign o_sat_rem    = r2_sat_rem;
    assign o_sat_low    = r2_sat_low;
    assign o_sat_div    = r2_sat_div;
    assign o_brightness = r2_bright;

endmodule

// ----- design/rhsv_divpipe.sv -----
// rhsv_divpipe: restoring dividers for hue and saturation, one quotient bit per
// register stage, both running in one pipeline. No package dependencies.
module rhsv_divpipe #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16,
    parameter int HDW          = CHANNEL_BITS + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // upstream side
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [HDW-1:0]          i_hue_rem,
    input  logic [HDW-1:0]          i_hue_div,
    input  logic [CHANNEL_BITS-1:0] i_sat_rem,
    input  logic [CHANNEL_BITS-1:0] i_sat_low,
    input  logic [CHANNEL_BITS-1:0] i_sat_div,
    input  logic [CHANNEL_BITS-1:0] i_brightness,
    // downstream side
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [HUE_BITS-1:0]     o_hue,
    output logic [CHANNEL_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness
);

    localparam int CB = CHANNEL_BITS;
    localparam int HB = HUE_BITS;
    localparam int L  = (HB > CB) ? HB : CB;

    logic [L:0]    w_rdy;

    // stage registers
    logic          r_valid  [L];
    logic [HDW-1:0] r_hrem  [L];
    logic [HDW-1:0] r_hdiv  [L];
    logic [HB-1:0] r_hq     [L];
    logic [CB-1:0] r_srem   [L];
    logic [CB-1:0] r_slow   [L];
    logic [CB-1:0] r_sdiv   [L];
    logic [CB-1:0] r_sq     [L];
    logic [CB-1:0] r_bright [L];

    // inputs seen by each stage
    logic          p_valid  [L];
    logic [HDW-1:0] p_hrem  [L];
    logic [HDW-1:0] p_hdiv  [L];
    logic [HB-1:0] p_hq     [L];
    logic [CB-1:0] p_srem   [L];
    logic [CB-1:0] p_slow   [L];
    logic [CB-1:0] p_sdiv   [L];
    logic [CB-1:0] p_sq     [L];
    logic [CB-1:0] p_bright [L];

    assign w_rdy[L] = i_ready;
    assign o_ready  = w_rdy[0];

    genvar gi;
    generate
        for (gi = 0; gi < L; gi++) begin : g_stage
            logic [HDW-1:0] n_hrem;
            logic [HB-1:0]  n_hq;
            logic [CB-1:0]  n_srem;
            logic [CB-1:0]  n_slow;
            logic [CB-1:0]  n_sq;

            // stage source: module inputs for the first, previous stage otherwise
            if (gi == 0) begin : g_src_in
                assign p_valid[gi]  = i_valid;
                assign p_hrem[gi]   = i_hue_rem;
                assign p_hdiv[gi]   = i_hue_div;
                assign p_hq[gi]     = '0;
                assign p_srem[gi]   = i_sat_rem;
                assign p_slow[gi]   = i_sat_low;
                assign p_sdiv[gi]   = i_sat_div;
                assign p_sq[gi]     = '0;
                assign p_bright[gi] = i_brightness;
            end else begin : g_src_reg
                assign p_valid[gi]  = r_valid[gi-1];
                assign p_hrem[gi]   = r_hrem[gi-1];
                assign p_hdiv[gi]   = r_hdiv[gi-1];
                assign p_hq[gi]     = r_hq[gi-1];
                assign p_srem[gi]   = r_srem[gi-1];
                assign p_slow[gi]   = r_slow[gi-1];
                assign p_sdiv[gi]   = r_sdiv[gi-1];
                assign p_sq[gi]     = r_sq[gi-1];
                assign p_bright[gi] = r_bright[gi-1];
            end

            // hue step: numerator low bits are all zero
            if (gi >= L - HB) begin : g_hue_step
                logic [HDW:0] w_hext;
                logic         w_hge;

                assign w_hext = {p_hrem[gi], 1'b0};
                assign w_hge  = (w_hext >= {1'b0, p_hdiv[gi]});

                always_comb begin
                    if (w_hge) begin
                        n_hrem = HDW'(w_hext - {1'b0, p_hdiv[gi]});
                    end else begin
                        n_hrem = w_hext[HDW-1:0];
                    end
                    n_hq = {p_hq[gi][HB-2:0], w_hge};
                end
            end else begin : g_hue_pass
                assign n_hrem = p_hrem[gi];
                assign n_hq   = p_hq[gi];
            end

            // saturation step: next dividend bit comes off the top of the low word
            if (gi >= L - CB) begin : g_sat_step
                logic [CB:0] w_sext;
                logic        w_sge;

                assign w_sext = {p_srem[gi], p_slow[gi][CB-1]};
                assign w_sge  = (w_sext >= {1'b0, p_sdiv[gi]});

                always_comb begin
                    if (w_sge) begin
                        n_srem = CB'(w_sext - {1'b0, p_sdiv[gi]});
                    end else begin
                        n_srem = w_sext[CB-1:0];
                    end
                    n_slow = {p_slow[gi][CB-2:0], 1'b0};
                    n_sq   = {p_sq[gi][CB-2:0], w_sge};
                end
            end else begin : g_sat_pass
                assign n_srem = p_srem[gi];
                assign n_slow = p_slow[gi];
                assign n_sq   = p_sq[gi];
            end

            assign w_rdy[gi] = !r_valid[gi] || w_rdy[gi+1];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[gi] <= 1'b0;
                end else if (w_rdy[gi]) begin
                    r_valid[gi] <= p_valid[gi];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[gi] && p_valid[gi]) begin
                    r_hrem[gi]   <= n_hrem;
                    r_hdiv[gi]   <= p_hdiv[gi];
                    r_hq[gi]     <= n_hq;
                    r_srem[gi]   <= n_srem;
                    r_slow[gi]   <= n_slow;
                    r_sdiv[gi]   <= p_sdiv[gi];
                    r_sq[gi]     <= n_sq;
                    r_bright[gi] <= p_bright[gi];
                end
            end
        end
    endgenerate

    // last stage doubles as the output register
    assign o_valid      = r_valid[L-1];
    assign o_hue        = r_hq[L-1];
    assign o_saturation = r_sq[L-1];
    assign o_brightness = r_bright[L-1];

endmodule

// ----- design/rgb_to_hsv_pixel.sv -----
// rgb_to_hsv_pixel: top level of the RGB to HSV pixel converter.
// Instantiates rhsv_front and rhsv_divpipe; rhsv_pkg is used by rhsv_front.
//
// Takes one pixel per clock while o_stall is low and returns one HSV result per
// pixel, in order. Two stages form max, min, chroma and the hue numerator, then
// two restoring dividers retire one quotient bit per stage side by side. The last
// divider stage is the output register, so a stalled result holds while the
// stages behind it keep filling; o_stall rises only once every stage is occupied.
module rgb_to_hsv_pixel #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [HUE_BITS-1:0]     o_hue,
    output logic [CHANNEL_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness
);

    localparam int HDW = CHANNEL_BITS + 3;

    logic                    w_front_ready;
    logic                    w_mid_valid;
    logic                    w_mid_ready;
    logic [HDW-1:0]          w_hue_rem;
    logic [HDW-1:0]          w_hue_div;
    logic [CHANNEL_BITS-1:0] w_sat_rem;
    logic [CHANNEL_BITS-1:0] w_sat_low;
    logic [CHANNEL_BITS-1:0] w_sat_div;
    logic [CHANNEL_BITS-1:0] w_bright;

    assign o_stall = !w_front_ready;

    // operand preparation
    rhsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HDW          (HDW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (w_front_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (w_mid_valid),
        .i_ready      (w_mid_ready),
        .o_hue_rem    (w_hue_rem),
        .o_hue_div    (w_hue_div),
        .o_sat_rem    (w_sat_rem),
        .o_sat_low    (w_sat_low),
        .o_sat_div    (w_sat_div),
        .o_brightness (w_bright)
    );

    // bit-per-stage dividers and output register
    rhsv_divpipe #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_BITS     (HUE_BITS),
        .HDW          (HDW)
    ) u_divpipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_mid_valid),
        .o_ready      (w_mid_ready),
        .i_hue_rem    (w_hue_rem),
        .i_hue_div    (w_hue_div),
        .i_sat_rem    (w_sat_rem),
        .i_sat_low    (w_sat_low),
        .i_sat_div    (w_sat_div),
        .i_brightness (w_bright),
        .o_valid      (o_valid),
        .i_ready      (!i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

endmodule
